// ----- sv/cubic_bezier_point_generator_unit_macros.svh -----
// Assertion macros shared by the cubic Bezier point generator RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef CUBIC_BEZIER_POINT_GENERATOR_UNIT_MACROS_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CBEZ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CBEZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cbez_pkg.sv -----
// Shared types, constants and the coefficient function of the Bezier unit.
// No dependencies; every other file but the macro header imports this package.
package cbez_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 13;
  localparam int OUT_W     = 24;

  localparam int MAX_POINTS           = 4096;
  localparam int DEN_W                = $clog2(MAX_POINTS);
  localparam int PARAM_FRAC_BITS_DEF  = 16;
  localparam int OUT_FRAC_BITS        = 8;

  // Power-basis coefficient widths for 16-bit control points.
  localparam int A_W = 19;
  localparam int B_W = 20;
  localparam int C_W = 19;
  localparam int COEF_CALC_W = CFG_W + 5;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_CTRL1_X,
    REG_CTRL1_Y,
    REG_CTRL2_X,
    REG_CTRL2_Y,
    REG_END_X,
    REG_END_Y
  } cfg_reg_t;

  typedef struct packed {
    logic signed [A_W-1:0]   a;
    logic signed [B_W-1:0]   b;
    logic signed [C_W-1:0]   c;
    logic signed [CFG_W-1:0] p0;
  } coef_t;

  // c = 3(p1-p0), b = 3(p2-p1) - c, a = p3 - p0 - 3(p2-p1)
  function automatic coef_t coef_calc(input logic signed [CFG_W-1:0] p0,
                                      input logic signed [CFG_W-1:0] p1,
                                      input logic signed [CFG_W-1:0] p2,
                                      input logic signed [CFG_W-1:0] p3);
    logic signed [COEF_CALC_W-1:0] d10;
    logic signed [COEF_CALC_W-1:0] d21;
    logic signed [COEF_CALC_W-1:0] cc;
    logic signed [COEF_CALC_W-1:0] cb;
    logic signed [COEF_CALC_W-1:0] ca;
    coef_t res;
    d10 = COEF_CALC_W'(p1) - COEF_CALC_W'(p0);
    d21 = COEF_CALC_W'(p2) - COEF_CALC_W'(p1);
    cc  = d10 + (d10 <<< 1);
    cb  = d21 + (d21 <<< 1) - cc;
    ca  = COEF_CALC_W'(p3) - COEF_CALC_W'(p0) - d21 - (d21 <<< 1);
    res.a  = ca[A_W-1:0];
    res.b  = cb[B_W-1:0];
    res.c  = cc[C_W-1:0];
    res.p0 = p0;
    return res;
  endfunction

endpackage

// ----- sv/cbez_if.sv -----
// Valid/ready channel interfaces for sample requests and curve points.
// Depends on cbez_pkg for field widths.
interface cbez_in_if import cbez_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;
  logic [CNT_W-1:0] sample_count;

  modport source (output valid, sample_index, sample_count, input ready);
  modport sink   (input valid, sample_index, sample_count, output ready);
endinterface

interface cbez_out_if import cbez_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] curve_x;
  logic signed [OUT_W-1:0] curve_y;

  modport source (output valid, curve_x, curve_y, input ready);
  modport sink   (input valid, curve_x, curve_y, output ready);
endinterface

// ----- sv/cbez_div.sv -----
// Curve parameter pipeline: clamps count and index, then divides
// index/(count-1) one quotient bit per stage. Depends on cbez_pkg and the macros.
`include "cubic_bezier_point_generator_unit_macros.svh"

module cbez_div import cbez_pkg::*; #(
  parameter int F = PARAM_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [IDX_W-1:0] in_idx,
  input  logic [CNT_W-1:0] in_cnt,
  output logic             out_vld,
  output logic [F:0]       out_t
);

  localparam logic [F:0] T_ONE = (F+1)'(1) << F;

  logic [CNT_W-1:0] cnt_one;
  logic [CNT_W-1:0] cnt_sat;
  logic [CNT_W-1:0] den_full;
  logic [CNT_W-1:0] idx_full;
  logic [CNT_W-1:0] idx_sat;
  logic             qint;

  logic [F:0]       vld_r;
  logic [F:0]       zero_r;
  logic [DEN_W-1:0] den_r [F+1];
  logic [DEN_W-1:0] rem_r [F+1];
  logic [F:0]       quo_r [F+1];

  // Count of zero acts as one; clamp count and index.
  assign cnt_one  = (in_cnt == '0) ? CNT_W'(1) : in_cnt;
  assign cnt_sat  = (cnt_one > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cnt_one;
  assign den_full = cnt_sat - CNT_W'(1);
  assign idx_full = CNT_W'(in_idx);
  assign idx_sat  = (idx_full > den_full) ? den_full : idx_full;
  assign qint     = (idx_sat == den_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[F-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r   <= {zero_r[F-1:0], (den_full == '0)};
      den_r[0] <= den_full[DEN_W-1:0];
      rem_r[0] <= qint ? '0 : idx_sat[DEN_W-1:0];
      quo_r[0] <= (F+1)'(qint);
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_stage
    logic [DEN_W:0] r2;
    logic [DEN_W:0] dx;
    logic           ge;

    assign r2 = {rem_r[k], 1'b0};
    assign dx = {1'b0, den_r[k]};
    assign ge = (r2 >= dx);

    // Shift, trial subtract, keep on success.
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1] <= den_r[k];
        rem_r[k+1] <= ge ? DEN_W'(r2 - dx) : r2[DEN_W-1:0];
        quo_r[k+1] <= {quo_r[k][F-1:0], ge};
      end
    end
  end

  assign out_vld = vld_r[F];
  assign out_t   = zero_r[F] ? '0 : quo_r[F];

  `CBEZ_ASSERT_IMPL(a_t_le_one, out_vld, out_t <= T_ONE, "curve parameter above one")
  `CBEZ_ASSERT_IMPL(a_int_bit_exact, out_vld && !zero_r[F] && quo_r[F][F], quo_r[F][F-1:0] == '0, "quotient above one")
  `CBEZ_ASSERT_IMPL(a_rem_below_den, out_vld && !zero_r[F], rem_r[F] < den_r[F], "remainder not reduced")

endmodule

// ----- sv/cbez_pow.sv -----
// Powers of the curve parameter: t^2 and t^3 truncated to F fraction bits,
// two register stages. Depends on cbez_pkg.
module cbez_pow import cbez_pkg::*; #(
  parameter int F = PARAM_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  logic [F:0] in_t,
  output logic       out_vld,
  output logic [F:0] out_t,
  output logic [F:0] out_t2,
  output logic [F:0] out_t3
);

  logic [1:0]     vld_r;
  logic [F:0]     t_a_r;
  logic [F:0]     t_b_r;
  logic [F:0]     t2_b_r;
  logic [2*F+1:0] tt_r;
  logic [2*F+1:0] t2t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tt_r   <= in_t * in_t;
      t_a_r  <= in_t;
      t2_b_r <= tt_r[2*F:F];
      t2t_r  <= tt_r[2*F:F] * t_a_r;
      t_b_r  <= t_a_r;
    end
  end

  assign out_vld = vld_r[1];
  assign out_t   = t_b_r;
  assign out_t2  = t2_b_r;
  assign out_t3  = t2t_r[2*F:F];

endmodule

// ----- sv/cbez_axis.sv -----
// One coordinate lane: a*t3 + b*t2 + c*t + p0 over three register stages,
// then floor shift to the output format and saturate. Depends on cbez_pkg.
module cbez_axis import cbez_pkg::*; #(
  parameter int F = PARAM_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  coef_t                   coef,
  input  logic                    in_vld,
  input  logic [F:0]              in_t,
  input  logic [F:0]              in_t2,
  input  logic [F:0]              in_t3,
  output logic                    out_vld,
  output logic signed [OUT_W-1:0] res
);

  localparam int SUM_W = F + 21;
  localparam int SHL   = (OUT_FRAC_BITS >= F) ? OUT_FRAC_BITS - F : 0;
  localparam int SHR   = (OUT_FRAC_BITS >= F) ? 0 : F - OUT_FRAC_BITS;
  localparam int RW    = SUM_W + SHL;
  localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN);

  logic [2:0]               vld_r;
  logic signed [A_W+F+1:0]  at3_r;
  logic signed [B_W+F+1:0]  bt2_r;
  logic signed [C_W+F+1:0]  ct_r;
  logic signed [SUM_W-1:0]  sab_r;
  logic signed [SUM_W-1:0]  scp_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [RW-1:0]     wide;
  logic signed [RW-1:0]     scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      at3_r <= $signed(coef.a) * $signed({1'b0, in_t3});
      bt2_r <= $signed(coef.b) * $signed({1'b0, in_t2});
      ct_r  <= $signed(coef.c) * $signed({1'b0, in_t});
      sab_r <= SUM_W'(at3_r) + SUM_W'(bt2_r);
      scp_r <= SUM_W'(ct_r) + (SUM_W'($signed(coef.p0)) <<< F);
      sum_r <= sab_r + scp_r;
    end
  end

  // Arithmetic right shift rounds toward minus infinity.
  assign wide   = RW'(sum_r);
  assign scaled = (wide <<< SHL) >>> SHR;

  always_comb begin
    if (scaled > SAT_HI) begin
      res = OUT_MAX;
    end else if (scaled < SAT_LO) begin
      res = OUT_MIN;
    end else begin
      res = scaled[OUT_W-1:0];
    end
  end

  assign out_vld = vld_r[2];

endmodule

// ----- sv/cubic_bezier_point_generator_unit.sv -----
// Top level of the cubic Bezier point generator: config registers, lanes,
// output register. Depends on cbez_pkg, cbez_if, cbez_div, cbez_pow, cbez_axis.
//
// Usage:
//   Write the four control points P0..P3 (x and y, 16-bit signed) through the
//   cfg_ port: cfg_we high for one cycle with cfg_idx selecting the register.
//   Write them only while no beat is in flight.
//   Each in_ch beat carries sample_index and sample_count; each out_ch beat
//   returns curve_x and curve_y, signed with OUT_FRAC_BITS fraction bits,
//   one result per request, in request order.
// Timing:
//   From accept to out_ch.valid a beat passes one clamp stage, one divider
//   stage per fraction bit, two power stages, three multiply/add stages and
//   the output register. Throughput is one beat per cycle while the pipeline
//   is not stalled by out_ch.ready.
// Reset:
//   rst_n (synchronous) clears all valid bits and zeroes the control points.
// Backpressure:
//   The pipeline advances unless its last stage holds a beat while the output
//   register is full and out_ch.ready is low; only then is in_ch.ready low.
//   Beats keep advancing toward the last stage while a result waits, so nothing is dropped or repeated.
`include "cubic_bezier_point_generator_unit_macros.svh"

module cubic_bezier_point_generator_unit import cbez_pkg::*; #(
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  cbez_in_if.sink              in_ch,
  cbez_out_if.source           out_ch
);

  localparam int F = PARAM_FRAC_BITS;

  // Control point registers.
  logic signed [CFG_W-1:0] start_x_r, start_y_r;
  logic signed [CFG_W-1:0] ctrl1_x_r, ctrl1_y_r;
  logic signed [CFG_W-1:0] ctrl2_x_r, ctrl2_y_r;
  logic signed [CFG_W-1:0] end_x_r, end_y_r;

  // Coefficients, recomputed every cycle from the registers.
  coef_t coef_x_r;
  coef_t coef_y_r;

  // Pipeline wiring.
  logic       pipe_en;
  logic       div_vld;
  logic [F:0] div_t;
  logic       pow_vld;
  logic [F:0] pow_t, pow_t2, pow_t3;
  logic       vld_x, vld_y;
  logic       last_vld;
  logic signed [OUT_W-1:0] res_x, res_y;

  // Output register.
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_x_r;
  logic signed [OUT_W-1:0] out_y_r;
  logic                    out_take;

  // Decode config writes by register index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      ctrl1_x_r <= '0;
      ctrl1_y_r <= '0;
      ctrl2_x_r <= '0;
      ctrl2_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START_X: start_x_r <= cfg_wdata;
        REG_START_Y: start_y_r <= cfg_wdata;
        REG_CTRL1_X: ctrl1_x_r <= cfg_wdata;
        REG_CTRL1_Y: ctrl1_y_r <= cfg_wdata;
        REG_CTRL2_X: ctrl2_x_r <= cfg_wdata;
        REG_CTRL2_Y: ctrl2_y_r <= cfg_wdata;
        REG_END_X:   end_x_r   <= cfg_wdata;
        REG_END_Y:   end_y_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coefficients settle in the cycle after a write, long before any beat
  // reaches the multipliers.
  always_ff @(posedge clk) begin
    coef_x_r <= coef_calc(start_x_r, ctrl1_x_r, ctrl2_x_r, end_x_r);
    coef_y_r <= coef_calc(start_y_r, ctrl1_y_r, ctrl2_y_r, end_y_r);
  end

  // Stall only when the last stage has a beat with nowhere to go.
  assign last_vld    = vld_x;
  assign out_take    = !out_valid_r || out_ch.ready;
  assign pipe_en     = !last_vld || out_take;
  assign in_ch.ready = pipe_en;

  cbez_div #(.F(F)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (in_ch.valid),
    .in_idx  (in_ch.sample_index),
    .in_cnt  (in_ch.sample_count),
    .out_vld (div_vld),
    .out_t   (div_t)
  );

  cbez_pow #(.F(F)) u_pow (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (div_vld),
    .in_t    (div_t),
    .out_vld (pow_vld),
    .out_t   (pow_t),
    .out_t2  (pow_t2),
    .out_t3  (pow_t3)
  );

  cbez_axis #(.F(F)) u_axis_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .coef    (coef_x_r),
    .in_vld  (pow_vld),
    .in_t    (pow_t),
    .in_t2   (pow_t2),
    .in_t3   (pow_t3),
    .out_vld (vld_x),
    .res     (res_x)
  );

  cbez_axis #(.F(F)) u_axis_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .coef    (coef_y_r),
    .in_vld  (pow_vld),
    .in_t    (pow_t),
    .in_t2   (pow_t2),
    .in_t3   (pow_t3),
    .out_vld (vld_y),
    .res     (res_y)
  );

  // Load the output register whenever it is free or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= last_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && last_vld) begin
      out_x_r <= res_x;
      out_y_r <= res_y;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.curve_x = out_x_r;
  assign out_ch.curve_y = out_y_r;

  `CBEZ_ASSERT_IMPL(a_lanes_aligned, 1'b1, vld_x == vld_y, "x and y lanes out of step")
  `CBEZ_ASSERT_IMPL(a_block_when_full, last_vld && out_valid_r && !out_ch.ready, !in_ch.ready, "input taken while pipeline blocked")
  `CBEZ_ASSERT_NEXT(a_result_loaded, last_vld && pipe_en, out_valid_r, "finished beat not loaded")

endmodule
